// ===== rtl/core/bus_voltage_window_monitor_top_assert.svh =====
// Assertion helpers for the bus voltage window monitor checker.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef BUS_VOLTAGE_WINDOW_MONITOR_TOP_ASSERT_SVH
`define BUS_VOLTAGE_WINDOW_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication
`define BVWM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BVWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bvwm_pkg.sv =====
package bvwm_pkg;

  localparam int unsigned DividerRatioDefault = 12;
  localparam int unsigned AdcW    = 12;
  localparam int unsigned MvW     = 16;
  localparam int unsigned CntW    = 8;
  localparam int unsigned VxW     = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MaxRecs = 5;
  localparam int unsigned RecIdxW = 3;

  // Reciprocal of ten for 16-bit operands: (x * 52429) >> 19
  localparam logic [MvW-1:0] Recip10   = 16'd52429;
  localparam int unsigned    Recip10Sh = 19;

  typedef enum logic [CfgIdxW-1:0] {
    RegOverThr   = 3'd0,
    RegOverHys   = 3'd1,
    RegOverTrig  = 3'd2,
    RegUnderThr  = 3'd3,
    RegUnderHys  = 3'd4,
    RegUnderTrig = 3'd5,
    RegAutoClear = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    ActSample = 1'b0,
    ActClear  = 1'b1
  } action_e;

  typedef enum logic {
    AlarmOver  = 1'b0,
    AlarmUnder = 1'b1
  } alarm_e;

  typedef enum logic {
    KindEvent  = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  typedef struct packed {
    logic [MvW-1:0]  over_thr;
    logic [MvW-1:0]  over_hys;
    logic [CntW-1:0] over_trig;
    logic [MvW-1:0]  under_thr;
    logic [MvW-1:0]  under_hys;
    logic [CntW-1:0] under_trig;
    logic            auto_clear;
  } cfg_t;

  typedef struct packed {
    logic           kind;
    logic           alarm_type;
    logic           is_active;
    logic [MvW-1:0] threshold_mv;
  } rec_t;

  typedef struct packed {
    rec_t [MaxRecs-1:0] recs;
    logic [RecIdxW-1:0] count;
    logic [MvW-1:0]     bus_mv;
    logic [VxW-1:0]     bus_vx100;
    logic               over_alarm;
    logic               under_alarm;
  } batch_t;

  // Divide a 16-bit value by ten with a reciprocal multiply
  function automatic logic [VxW-1:0] div10(input logic [MvW-1:0] x);
    logic [2*MvW-1:0] prod;
    prod = {{MvW{1'b0}}, x} * {{MvW{1'b0}}, Recip10};
    return prod[Recip10Sh +: VxW];
  endfunction

endpackage

// ===== rtl/core/bvwm_in_if.sv =====
interface bvwm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [bvwm_pkg::AdcW-1:0]   adc_mv;
  logic                        clear_type;

  modport source (output valid, action, adc_mv, clear_type, input ready);
  modport sink   (input valid, action, adc_mv, clear_type, output ready);
endinterface

// ===== rtl/core/bvwm_out_if.sv =====
interface bvwm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      alarm_type;
  logic                      is_active;
  logic [bvwm_pkg::MvW-1:0]  bus_mv;
  logic [bvwm_pkg::MvW-1:0]  threshold_mv;
  logic [bvwm_pkg::VxW-1:0]  bus_vx100;
  logic                      over_alarm;
  logic                      under_alarm;
  logic                      last;

  modport source (output valid, kind, alarm_type, is_active, bus_mv, threshold_mv,
                  bus_vx100, over_alarm, under_alarm, last, input ready);
  modport sink   (input valid, kind, alarm_type, is_active, bus_mv, threshold_mv,
                  bus_vx100, over_alarm, under_alarm, last, output ready);
endinterface

// ===== rtl/core/bvwm_core.sv =====
module bvwm_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bvwm_pkg::cfg_t           cfg_i,
  input  logic                     eval_i,
  input  logic                     action_i,
  input  logic                     clear_type_i,
  input  logic [bvwm_pkg::MvW-1:0] bus_mv_i,
  output bvwm_pkg::batch_t         batch_o
);

  logic                      over_flag_q, over_flag_d;
  logic                      under_flag_q, under_flag_d;
  logic [bvwm_pkg::CntW-1:0] over_run_q, over_run_d;
  logic [bvwm_pkg::CntW-1:0] under_run_q, under_run_d;
  logic [bvwm_pkg::MvW-1:0]  over_rel_q, over_rel_d;
  logic [bvwm_pkg::MvW:0]    under_rel_q, under_rel_d;
  logic [bvwm_pkg::MvW-1:0]  last_bus_q, last_bus_d;

  bvwm_pkg::rec_t [bvwm_pkg::MaxRecs-1:0] recs;
  logic [bvwm_pkg::RecIdxW-1:0]           n;
  logic [bvwm_pkg::MvW-1:0]               bus;
  bvwm_pkg::rec_t                         ev;

  // Evaluate one item against the alarm state, appending records in order
  always_comb begin
    over_flag_d  = over_flag_q;
    under_flag_d = under_flag_q;
    over_run_d   = over_run_q;
    under_run_d  = under_run_q;
    over_rel_d   = over_rel_q;
    under_rel_d  = under_rel_q;
    last_bus_d   = last_bus_q;
    recs         = '0;
    n            = '0;
    ev           = '0;
    bus          = last_bus_q;

    if (bvwm_pkg::action_e'(action_i) == bvwm_pkg::ActSample) begin
      bus        = bus_mv_i;
      last_bus_d = bus_mv_i;

      // Over-voltage side
      if (bus >= cfg_i.over_thr) begin
        if (under_flag_d) begin
          under_flag_d = 1'b0;
          under_run_d  = '0;
          ev = '{bvwm_pkg::KindEvent, bvwm_pkg::AlarmUnder, 1'b0, cfg_i.under_thr};
          recs[n] = ev;
          n = n + 1'b1;
        end
        if (over_run_d != {bvwm_pkg::CntW{1'b1}}) begin
          over_run_d = over_run_d + 1'b1;
        end
        if (over_run_d >= cfg_i.over_trig && !over_flag_d) begin
          over_flag_d = 1'b1;
          over_rel_d  = (cfg_i.over_hys > cfg_i.over_thr) ? {bvwm_pkg::MvW{1'b1}}
                                                          : cfg_i.over_thr - cfg_i.over_hys;
          ev = '{bvwm_pkg::KindEvent, bvwm_pkg::AlarmOver, 1'b1, cfg_i.over_thr};
          recs[n] = ev;
          n = n + 1'b1;
        end
      end else if (bus <= over_rel_d) begin
        if (over_flag_d) begin
          over_flag_d = 1'b0;
          if (cfg_i.auto_clear) begin
            ev = '{bvwm_pkg::KindEvent, bvwm_pkg::AlarmOver, 1'b0, cfg_i.over_thr};
            recs[n] = ev;
            n = n + 1'b1;
          end
        end
        over_run_d = '0;
      end else if (!over_flag_d) begin
        over_run_d = '0;
      end

      // Under-voltage side
      if (bus <= cfg_i.under_thr) begin
        if (over_flag_d) begin
          over_flag_d = 1'b0;
          over_run_d  = '0;
          ev = '{bvwm_pkg::KindEvent, bvwm_pkg::AlarmOver, 1'b0, cfg_i.over_thr};
          recs[n] = ev;
          n = n + 1'b1;
        end
        if (under_run_d != {bvwm_pkg::CntW{1'b1}}) begin
          under_run_d = under_run_d + 1'b1;
        end
        if (under_run_d >= cfg_i.under_trig && !under_flag_d) begin
          under_flag_d = 1'b1;
          under_rel_d  = {1'b0, cfg_i.under_thr} + {1'b0, cfg_i.under_hys};
          ev = '{bvwm_pkg::KindEvent, bvwm_pkg::AlarmUnder, 1'b1, cfg_i.under_thr};
          recs[n] = ev;
          n = n + 1'b1;
        end
      end else if ({1'b0, bus} >= under_rel_d) begin
        if (under_flag_d) begin
          under_flag_d = 1'b0;
          if (cfg_i.auto_clear) begin
            ev = '{bvwm_pkg::KindEvent, bvwm_pkg::AlarmUnder, 1'b0, cfg_i.under_thr};
            recs[n] = ev;
            n = n + 1'b1;
          end
        end
        under_run_d = '0;
      end else if (!under_flag_d) begin
        under_run_d = '0;
      end
    end else if (bvwm_pkg::alarm_e'(clear_type_i) == bvwm_pkg::AlarmOver) begin
      // Manual clear of the over-voltage alarm
      if (over_flag_d) begin
        over_flag_d = 1'b0;
        over_run_d  = '0;
        ev = '{bvwm_pkg::KindEvent, bvwm_pkg::AlarmOver, 1'b0, cfg_i.over_thr};
        recs[n] = ev;
        n = n + 1'b1;
      end
    end else begin
      // Manual clear of the under-voltage alarm
      if (under_flag_d) begin
        under_flag_d = 1'b0;
        under_run_d  = '0;
        ev = '{bvwm_pkg::KindEvent, bvwm_pkg::AlarmUnder, 1'b0, cfg_i.under_thr};
        recs[n] = ev;
        n = n + 1'b1;
      end
    end

    // Status record closes the batch
    ev = '{bvwm_pkg::KindStatus, bvwm_pkg::AlarmOver, 1'b0, {bvwm_pkg::MvW{1'b0}}};
    recs[n] = ev;
    n = n + 1'b1;
  end

  assign batch_o.recs        = recs;
  assign batch_o.count       = n;
  assign batch_o.bus_mv      = bus;
  assign batch_o.bus_vx100   = bvwm_pkg::div10(bus);
  assign batch_o.over_alarm  = over_flag_d;
  assign batch_o.under_alarm = under_flag_d;

  // Commit alarm state when the batch is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_flag_q  <= 1'b0;
      under_flag_q <= 1'b0;
      over_run_q   <= '0;
      under_run_q  <= '0;
      over_rel_q   <= '0;
      under_rel_q  <= '0;
      last_bus_q   <= '0;
    end else if (eval_i) begin
      over_flag_q  <= over_flag_d;
      under_flag_q <= under_flag_d;
      over_run_q   <= over_run_d;
      under_run_q  <= under_run_d;
      over_rel_q   <= over_rel_d;
      under_rel_q  <= under_rel_d;
      last_bus_q   <= last_bus_d;
    end
  end

endmodule

// ===== rtl/core/bus_voltage_window_monitor_top.sv =====
// Bus voltage window monitor.
// sample_i carries one item per handshake: a new ADC sample (action 0, adc_mv
// in divider-node millivolts) or a manual clear of one alarm (action 1,
// clear_type). result_o returns the records each item causes: zero to four
// alarm raise/release events, then one status record with last set.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must write it only while idle, which the block does not enforce. An item
// is held in the input register, then loaded into the result buffer.
// Throughput: one record per cycle on result_o while the receiver is ready;
// an item yields 1 to 5 records, and the next item is accepted into the
// input register meanwhile, so items with only a status record flow at one
// per cycle; the result buffer drain sets the rate. Reset clears both alarms,
// run counters, release levels and the last bus voltage, and loads register
// defaults (over threshold 65535, trigger counts 1, auto-clear on). When the
// receiver stalls, the current record holds, the buffer stays full and
// sample_i.ready drops once the input register is also occupied.
module bus_voltage_window_monitor_top #(
  parameter int unsigned DIVIDER_RATIO = bvwm_pkg::DividerRatioDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bvwm_in_if.sink                       sample_i,
  bvwm_out_if.source                    result_o,
  input  logic                          cfg_we_i,
  input  logic [bvwm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bvwm_pkg::MvW-1:0]      cfg_wdata_i
);

  bvwm_pkg::cfg_t cfg_q;

  logic                     s1_valid_q;
  logic                     s1_action_q;
  logic                     s1_ctype_q;
  logic [bvwm_pkg::MvW-1:0] s1_bus_q;
  logic [bvwm_pkg::MvW-1:0] bus_mult;

  bvwm_pkg::batch_t                       batch;
  bvwm_pkg::rec_t [bvwm_pkg::MaxRecs-1:0] buf_q;
  logic [bvwm_pkg::RecIdxW-1:0]           cnt_q;
  logic [bvwm_pkg::MvW-1:0]               bus_q;
  logic [bvwm_pkg::VxW-1:0]               vx_q;
  logic                                   over_q;
  logic                                   under_q;

  logic load;
  logic pop;
  logic in_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.over_thr   <= {bvwm_pkg::MvW{1'b1}};
      cfg_q.over_hys   <= '0;
      cfg_q.over_trig  <= bvwm_pkg::CntW'(1);
      cfg_q.under_thr  <= '0;
      cfg_q.under_hys  <= '0;
      cfg_q.under_trig <= bvwm_pkg::CntW'(1);
      cfg_q.auto_clear <= 1'b1;
    end else if (cfg_we_i) begin
      case (bvwm_pkg::cfg_reg_e'(cfg_idx_i))
        bvwm_pkg::RegOverThr:   cfg_q.over_thr   <= cfg_wdata_i;
        bvwm_pkg::RegOverHys:   cfg_q.over_hys   <= cfg_wdata_i;
        bvwm_pkg::RegOverTrig:  cfg_q.over_trig  <= cfg_wdata_i[bvwm_pkg::CntW-1:0];
        bvwm_pkg::RegUnderThr:  cfg_q.under_thr  <= cfg_wdata_i;
        bvwm_pkg::RegUnderHys:  cfg_q.under_hys  <= cfg_wdata_i;
        bvwm_pkg::RegUnderTrig: cfg_q.under_trig <= cfg_wdata_i[bvwm_pkg::CntW-1:0];
        bvwm_pkg::RegAutoClear: cfg_q.auto_clear <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Handshake control
  assign pop            = result_o.valid && result_o.ready;
  assign load           = s1_valid_q &&
                          ((cnt_q == '0) || ((cnt_q == bvwm_pkg::RecIdxW'(1)) && result_o.ready));
  assign sample_i.ready = !s1_valid_q || load;
  assign in_take        = sample_i.valid && sample_i.ready;

  // Scale divider-node millivolts to bus millivolts
  assign bus_mult = bvwm_pkg::MvW'(sample_i.adc_mv) * bvwm_pkg::MvW'(DIVIDER_RATIO);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_action_q <= sample_i.action;
      s1_ctype_q  <= sample_i.clear_type;
      s1_bus_q    <= bus_mult;
    end
  end

  bvwm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .eval_i       (load),
    .action_i     (s1_action_q),
    .clear_type_i (s1_ctype_q),
    .bus_mv_i     (s1_bus_q),
    .batch_o      (batch)
  );

  // Result buffer: load a whole batch, shift one record out per pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= batch.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q   <= batch.recs;
      bus_q   <= batch.bus_mv;
      vx_q    <= batch.bus_vx100;
      over_q  <= batch.over_alarm;
      under_q <= batch.under_alarm;
    end else if (pop) begin
      for (int i = 0; i < bvwm_pkg::MaxRecs - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  // Present the head record
  assign result_o.valid        = (cnt_q != '0);
  assign result_o.kind         = buf_q[0].kind;
  assign result_o.alarm_type   = buf_q[0].alarm_type;
  assign result_o.is_active    = buf_q[0].is_active;
  assign result_o.threshold_mv = buf_q[0].threshold_mv;
  assign result_o.bus_mv       = bus_q;
  assign result_o.bus_vx100    = vx_q;
  assign result_o.over_alarm   = over_q;
  assign result_o.under_alarm  = under_q;
  assign result_o.last         = (cnt_q == bvwm_pkg::RecIdxW'(1));

endmodule

// ===== rtl/core/bvwm_checker.sv =====
`include "bus_voltage_window_monitor_top_assert.svh"

module bvwm_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     kind,
  input logic                     alarm_type,
  input logic                     is_active,
  input logic [bvwm_pkg::MvW-1:0] bus_mv,
  input logic [bvwm_pkg::MvW-1:0] threshold_mv,
  input logic [bvwm_pkg::VxW-1:0] bus_vx100,
  input logic                     over_alarm,
  input logic                     under_alarm,
  input logic                     last
);

  logic [bvwm_pkg::MvW:0] vx_times10;

  assign vx_times10 = {{(bvwm_pkg::MvW + 1 - bvwm_pkg::VxW){1'b0}}, bus_vx100} * 17'd10;

  `BVWM_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(last), "record dropped while stalled")
  `BVWM_ASSERT_IMPL(a_exclusive, out_valid, !(over_alarm && under_alarm), "both alarms active")
  `BVWM_ASSERT_IMPL(a_status_last, out_valid, (kind == last) && (!kind || (!alarm_type && !is_active && threshold_mv == '0)), "status record malformed")
  `BVWM_ASSERT_IMPL(a_vx_scale, out_valid, (vx_times10 <= {1'b0, bus_mv}) && ({1'b0, bus_mv} - vx_times10 < 17'd10), "bus_vx100 not bus_mv over ten")

endmodule

bind bus_voltage_window_monitor_top bvwm_checker u_bvwm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (result_o.valid),
  .out_ready    (result_o.ready),
  .kind         (result_o.kind),
  .alarm_type   (result_o.alarm_type),
  .is_active    (result_o.is_active),
  .bus_mv       (result_o.bus_mv),
  .threshold_mv (result_o.threshold_mv),
  .bus_vx100    (result_o.bus_vx100),
  .over_alarm   (result_o.over_alarm),
  .under_alarm  (result_o.under_alarm),
  .last         (result_o.last)
);
